// File: src/mkdb_pkg.sv
// ----------------------------------------------------------------------------
// mkdb_pkg: shared types and constants of the multi-key debouncer
// Key count, special key index, event codes, operation and register codes.
// ----------------------------------------------------------------------------
package mkdb_pkg;

	localparam int NUM_KEYS    = 6;
	localparam int SPECIAL_KEY = 5;
	localparam int MASK_W      = 6;
	localparam int CNT_W       = 4;
	localparam int EV_W        = 3;
	localparam int TIME_W      = 32;
	localparam int LONG_W      = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CNT_W-1:0]  DEBOUNCE_RESET = CNT_W'(3);
	localparam logic [LONG_W-1:0] LONG_MS_RESET  = LONG_W'(1000);

	localparam logic [EV_W-1:0] EV_NONE    = EV_W'(0);
	localparam logic [EV_W-1:0] EV_ORD_MAX = EV_W'(5);
	localparam logic [EV_W-1:0] EV_SPECIAL = EV_W'(6);
	localparam logic [EV_W-1:0] EV_LONG    = EV_W'(7);

	typedef enum logic [1:0] {
		OP_SCAN = 2'd0,
		OP_READ = 2'd1,
		OP_INIT = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_MS  = CFG_IDX_W'(1);

	// Event candidate offered by one key to the merge stage.
	typedef struct packed {
		logic            valid;
		logic [EV_W-1:0] code;
	} evt_cand_t;

	// Code of an ordinary key: its rank among ordinary keys plus one, saturated.
	function automatic logic [EV_W-1:0] ordinary_code(input int k);
		int rank;
		rank = (k > SPECIAL_KEY) ? k - 1 : k;
		if (rank + 1 > int'(EV_ORD_MAX))
			return EV_ORD_MAX;
		return EV_W'(rank + 1);
	endfunction

endpackage

// File: src/mkdb_lane.sv
// ----------------------------------------------------------------------------
// mkdb_lane: debounce core for one key
// Counts consecutive samples that differ from the stable level.
// ----------------------------------------------------------------------------
module mkdb_lane
	import mkdb_pkg::*;
(
	input  logic             sample,
	input  logic             level_q,
	input  logic [CNT_W-1:0] count_q,
	input  logic [CNT_W-1:0] debounce,
	output logic             level_d,
	output logic [CNT_W-1:0] count_d,
	output logic             accept
);

	logic [CNT_W-1:0] count_inc;

	assign count_inc = count_q + CNT_W'(1);

	always_comb begin
		level_d = level_q;
		count_d = '0;
		accept  = 1'b0;
		if (sample != level_q) begin
			if (count_inc < debounce) begin
				count_d = count_inc;
			end else begin
				level_d = sample;
				accept  = 1'b1;
			end
		end
	end

endmodule

// File: src/mkdb_special.sv
// ----------------------------------------------------------------------------
// mkdb_special: special key event logic
// Press on release, long press after the hold limit, ignore after init.
// ----------------------------------------------------------------------------
module mkdb_special
	import mkdb_pkg::*;
(
	input  logic              sample,
	input  logic              level_q,
	input  logic              accept,
	input  logic [TIME_W-1:0] now_ms,
	input  logic [LONG_W-1:0] long_ms,
	input  logic [TIME_W-1:0] hold_start_q,
	input  logic              long_rep_q,
	input  logic              ignore_q,
	input  logic              grant,
	output evt_cand_t         cand,
	output logic [TIME_W-1:0] hold_start_d,
	output logic              long_rep_d,
	output logic              ignore_d
);

	logic [TIME_W-1:0] held;
	logic              long_due;
	logic              long_rep_n;

	assign held     = now_ms - hold_start_q;
	assign long_due = held >= TIME_W'(long_ms);

	// Mark the long press as reported only once the merge stage latches it.
	assign long_rep_d = long_rep_n || (grant && cand.code == EV_LONG);

	always_comb begin
		cand.valid   = 1'b0;
		cand.code    = EV_NONE;
		hold_start_d = hold_start_q;
		long_rep_n   = long_rep_q;
		ignore_d     = ignore_q;
		if (sample == level_q) begin
			if (sample && !ignore_q && !long_rep_q && long_due) begin
				cand.valid = 1'b1;
				cand.code  = EV_LONG;
			end
		end else if (accept) begin
			if (sample) begin
				if (!ignore_q) begin
					hold_start_d = now_ms;
					long_rep_n   = 1'b0;
				end
			end else if (ignore_q) begin
				ignore_d   = 1'b0;
				long_rep_n = 1'b0;
			end else if (!long_rep_q) begin
				cand.valid = 1'b1;
				cand.code  = EV_SPECIAL;
			end
		end
	end

endmodule

// File: src/mkdb_merge.sv
// ----------------------------------------------------------------------------
// mkdb_merge: event merge stage
// Latch the lowest key's event, only while the pending latch is empty.
// ----------------------------------------------------------------------------
module mkdb_merge
	import mkdb_pkg::*;
(
	input  logic [NUM_KEYS-1:0] ord_cand,
	input  evt_cand_t           spec_cand,
	input  logic [EV_W-1:0]     pending_q,
	output logic [EV_W-1:0]     pending_d,
	output logic                spec_grant
);

	logic found;

	always_comb begin
		pending_d  = pending_q;
		spec_grant = 1'b0;
		found      = (pending_q != EV_NONE);
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (!found) begin
				if (k == SPECIAL_KEY) begin
					if (spec_cand.valid) begin
						pending_d  = spec_cand.code;
						spec_grant = 1'b1;
						found      = 1'b1;
					end
				end else if (ord_cand[k]) begin
					pending_d = ordinary_code(k);
					found     = 1'b1;
				end
			end
		end
	end

endmodule

// File: src/multi_key_debounce_long_press_top.sv
// ----------------------------------------------------------------------------
// multi_key_debounce_long_press_top: multi-key debouncer with long press
// One debounce lane per key, a special key unit and an event merge stage,
// followed by a two-entry output buffer.
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload
//  -------  -------------------  ----------------------------------------
//  input    in_valid / in_stall  operation, pressed_mask, now_ms
//  output   out_valid/out_stall  event_code, stable_mask
//  config   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// All lanes update the key state in the cycle of the input transfer, and
// the result is registered in the output buffer.
// A new item is taken every cycle as long as results are drained.
// The input stalls only when both output buffer entries are full.
// Reset clears all key state, the pending event and the registers to
// their defaults (debounce 3 samples, long press 1000 ms).
// ----------------------------------------------------------------------------
module multi_key_debounce_long_press_top
	import mkdb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            operation,
	input  logic [MASK_W-1:0]     pressed_mask,
	input  logic [TIME_W-1:0]     now_ms,
	// output channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [EV_W-1:0]       event_code,
	output logic [MASK_W-1:0]     stable_mask,
	// configuration channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic [CNT_W-1:0]  debounce_q;
	logic [LONG_W-1:0] long_ms_q;

	// key state
	logic [NUM_KEYS-1:0] level_q;
	logic [CNT_W-1:0]    count_q [NUM_KEYS];
	logic [EV_W-1:0]     pending_q;
	logic [TIME_W-1:0]   hold_start_q;
	logic                long_rep_q;
	logic                ignore_q;

	// output buffer
	logic              out_valid_q;
	logic [EV_W-1:0]   out_event_q;
	logic [MASK_W-1:0] out_mask_q;
	logic              skid_valid_q;
	logic [EV_W-1:0]   skid_event_q;
	logic [MASK_W-1:0] skid_mask_q;

	// lane results
	logic [NUM_KEYS-1:0] sample;
	logic [NUM_KEYS-1:0] level_d;
	logic [CNT_W-1:0]    count_d [NUM_KEYS];
	logic [NUM_KEYS-1:0] accept;
	logic [NUM_KEYS-1:0] ord_cand;

	evt_cand_t         spec_cand;
	logic              spec_grant;
	logic [TIME_W-1:0] hold_start_d;
	logic              long_rep_d;
	logic              ignore_d;
	logic [EV_W-1:0]   pending_d;

	logic              in_fire;
	logic              out_take;
	op_t               op;
	logic [EV_W-1:0]   res_event;
	logic [MASK_W-1:0] res_mask;
	logic [NUM_KEYS-1:0] level_next;

	assign op        = op_t'(operation);
	assign in_stall  = skid_valid_q;
	assign in_fire   = in_valid && !skid_valid_q;
	assign out_take  = out_valid_q && !out_stall;
	assign cfg_ready = 1'b1;

	// Keys past the mask width always sample as released.
	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		if (k < MASK_W) begin : g_in
			assign sample[k] = pressed_mask[k];
		end else begin : g_out
			assign sample[k] = 1'b0;
		end

		mkdb_lane u_lane (
			.sample   (sample[k]),
			.level_q  (level_q[k]),
			.count_q  (count_q[k]),
			.debounce (debounce_q),
			.level_d  (level_d[k]),
			.count_d  (count_d[k]),
			.accept   (accept[k])
		);

		// An ordinary key offers a press when a pressed level is accepted.
		if (k == SPECIAL_KEY) begin : g_spec
			assign ord_cand[k] = 1'b0;
		end else begin : g_ord
			assign ord_cand[k] = accept[k] && sample[k];
		end
	end

	mkdb_special u_special (
		.sample       (sample[SPECIAL_KEY]),
		.level_q      (level_q[SPECIAL_KEY]),
		.accept       (accept[SPECIAL_KEY]),
		.now_ms       (now_ms),
		.long_ms      (long_ms_q),
		.hold_start_q (hold_start_q),
		.long_rep_q   (long_rep_q),
		.ignore_q     (ignore_q),
		.grant        (spec_grant),
		.cand         (spec_cand),
		.hold_start_d (hold_start_d),
		.long_rep_d   (long_rep_d),
		.ignore_d     (ignore_d)
	);

	mkdb_merge u_merge (
		.ord_cand   (ord_cand),
		.spec_cand  (spec_cand),
		.pending_q  (pending_q),
		.pending_d  (pending_d),
		.spec_grant (spec_grant)
	);

	// Result of the current item: event on a read, levels after the step.
	always_comb begin
		level_next = level_q;
		res_event  = EV_NONE;
		case (op)
			OP_SCAN: level_next = level_d;
			OP_READ: res_event  = pending_q;
			OP_INIT: level_next = sample;
			default: level_next = level_q;
		endcase
		res_mask = '0;
		for (int k = 0; k < MASK_W; k++) begin
			if (k < NUM_KEYS)
				res_mask[k] = level_next[k];
		end
	end

	// Configuration writes; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			long_ms_q  <= LONG_MS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_DEBOUNCE)
				debounce_q <= cfg_data[CNT_W-1:0];
			else if (cfg_index == CFG_LONG_MS)
				long_ms_q <= cfg_data[LONG_W-1:0];
		end
	end

	// Key state update on every input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q      <= '0;
			pending_q    <= EV_NONE;
			hold_start_q <= '0;
			long_rep_q   <= 1'b0;
			ignore_q     <= 1'b0;
			for (int k = 0; k < NUM_KEYS; k++)
				count_q[k] <= '0;
		end else if (in_fire) begin
			case (op)
				OP_SCAN: begin
					level_q      <= level_d;
					pending_q    <= pending_d;
					hold_start_q <= hold_start_d;
					long_rep_q   <= long_rep_d;
					ignore_q     <= ignore_d;
					for (int k = 0; k < NUM_KEYS; k++)
						count_q[k] <= count_d[k];
				end
				OP_READ: begin
					pending_q <= EV_NONE;
				end
				OP_INIT: begin
					// Load levels from the sample; a held special key is ignored.
					level_q      <= sample;
					pending_q    <= EV_NONE;
					hold_start_q <= '0;
					long_rep_q   <= 1'b0;
					ignore_q     <= sample[SPECIAL_KEY];
					for (int k = 0; k < NUM_KEYS; k++)
						count_q[k] <= '0;
				end
				default: begin
					pending_q <= pending_q;
				end
			endcase
		end
	end

	// Output buffer: advance the skid entry when the head drains,
	// park a new result in the skid entry while the head is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_event_q <= skid_event_q;
				out_mask_q  <= skid_mask_q;
			end else if (in_fire) begin
				out_event_q <= res_event;
				out_mask_q  <= res_mask;
			end
		end else if (in_fire) begin
			skid_event_q <= res_event;
			skid_mask_q  <= res_mask;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_code  = out_event_q;
	assign stable_mask = out_mask_q;

endmodule

// File: tb/tb_multi_key_debounce_long_press_top.sv
// ----------------------------------------------------------------------------
// tb_multi_key_debounce_long_press_top: self-checking bench of the debouncer
// Drives scan, read, init and unused operations through the input channel.
// A behavioral copy of the key state predicts every result, and the output
// channel is checked field by field. Both sides idle and stall at random,
// and the debounce and long-press registers are retuned between phases.
// ----------------------------------------------------------------------------
module tb_multi_key_debounce_long_press_top
	import mkdb_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	// Spare register indexes: writes there must leave the block untouched.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);
	localparam int CYCLE_LIMIT = 100000;

	typedef struct {
		op_t               op;
		logic [MASK_W-1:0] mask;
		logic [TIME_W-1:0] tick;
	} key_sample_t;

	typedef struct {
		logic [EV_W-1:0]   event_code;
		logic [MASK_W-1:0] stable_mask;
	} key_report_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            operation = OP_NOP;
	logic [MASK_W-1:0]     pressed_mask = '0;
	logic [TIME_W-1:0]     now_ms = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [EV_W-1:0]       event_code;
	logic [MASK_W-1:0]     stable_mask;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Items waiting to be offered, and the reports the block still owes us.
	key_sample_t pending_samples[$];
	key_report_t due_reports[$];
	key_sample_t next_sample;
	key_report_t fresh_report;
	key_report_t want_report;

	// Shadow of the block state, kept in step with every accepted transfer.
	logic [NUM_KEYS-1:0] key_level = '0;
	logic [CNT_W-1:0]    diff_count [NUM_KEYS];
	logic [EV_W-1:0]     latched_event = EV_NONE;
	logic [TIME_W-1:0]   hold_t0 = '0;
	logic                long_done = 1'b0;
	logic                skip_special = 1'b0;
	logic [CNT_W-1:0]    tune_debounce = DEBOUNCE_RESET;
	logic [LONG_W-1:0]   tune_long_ms = LONG_MS_RESET;

	logic [TIME_W-1:0] ms_now = '0;
	bit                allow_gaps = 1'b1;
	int                mismatches = 0;
	int                cycle_count = 0;

	multi_key_debounce_long_press_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.pressed_mask (pressed_mask),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_code   (event_code),
		.stable_mask  (stable_mask),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		foreach (diff_count[k])
			diff_count[k] = '0;
	end

	// Advance the shadow state by one item and build the report it produces.
	task automatic debounce_step(input op_t op, input logic [MASK_W-1:0] mask,
			input logic [TIME_W-1:0] tick, output key_report_t rep);
		logic [TIME_W-1:0] held;
		logic              s;
		int                code;
		rep.event_code = EV_NONE;
		case (op)
			OP_SCAN: begin
				for (int k = 0; k < NUM_KEYS; k++) begin
					s = mask[k];
					if (s == key_level[k]) begin
						// Agreeing sample: drop the count, maybe fire the long press.
						diff_count[k] = '0;
						held = tick - hold_t0;
						if (k == SPECIAL_KEY && s && !skip_special && !long_done
								&& held >= TIME_W'(tune_long_ms)
								&& latched_event == EV_NONE) begin
							latched_event = EV_LONG;
							long_done = 1'b1;
						end
					end else begin
						diff_count[k] = diff_count[k] + 1'b1;
						// A zero threshold lets the first differing sample through.
						if (diff_count[k] >= tune_debounce) begin
							diff_count[k] = '0;
							key_level[k] = s;
							if (k == SPECIAL_KEY) begin
								if (s) begin
									if (!skip_special) begin
										hold_t0 = tick;
										long_done = 1'b0;
									end
								end else if (skip_special) begin
									skip_special = 1'b0;
									long_done = 1'b0;
								end else if (!long_done && latched_event == EV_NONE) begin
									latched_event = EV_SPECIAL;
								end
							end else if (s && latched_event == EV_NONE) begin
								// Ordinary keys above the special one shift down a rank.
								code = (k > SPECIAL_KEY) ? k : k + 1;
								if (code > int'(EV_ORD_MAX))
									code = int'(EV_ORD_MAX);
								latched_event = EV_W'(code);
							end
						end
					end
				end
			end
			OP_READ: begin
				rep.event_code = latched_event;
				latched_event = EV_NONE;
			end
			OP_INIT: begin
				latched_event = EV_NONE;
				hold_t0 = '0;
				long_done = 1'b0;
				key_level = mask;
				for (int k = 0; k < NUM_KEYS; k++)
					diff_count[k] = '0;
				// A special key held at init stays muted until it lets go.
				skip_special = mask[SPECIAL_KEY];
			end
			default: ;
		endcase
		rep.stable_mask = key_level;
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: %s mismatch: got %0d, want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// Input driver: predict on every transfer, hold a stalled item, otherwise
	// offer the next item unless a random gap is drawn.
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			debounce_step(op_t'(operation), pressed_mask, now_ms, fresh_report);
			due_reports.push_back(fresh_report);
		end
		if (in_valid && in_stall) begin
			// hold the payload until the block takes it
		end else if (pending_samples.size() != 0
				&& !(allow_gaps && $urandom_range(99) < 7)) begin
			next_sample = pending_samples.pop_front();
			in_valid <= 1'b1;
			operation <= next_sample.op;
			pressed_mask <= next_sample.mask;
			now_ms <= next_sample.tick;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Output monitor: stall at random, compare each transfer with the oldest
	// outstanding report.
	always @(posedge clk) begin
		out_stall <= allow_gaps && ($urandom_range(99) < 7);
		if (out_valid && !out_stall) begin
			if (due_reports.size() == 0) begin
				report_mismatch("unexpected result, event_code", event_code, -1);
			end else begin
				want_report = due_reports.pop_front();
				if (event_code !== want_report.event_code)
					report_mismatch("event_code", event_code, want_report.event_code);
				if (stable_mask !== want_report.stable_mask)
					report_mismatch("stable_mask", stable_mask, want_report.stable_mask);
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic add_item(input op_t op, input logic [MASK_W-1:0] mask,
			input logic [TIME_W-1:0] tick);
		key_sample_t s;
		s.op = op;
		s.mask = mask;
		s.tick = tick;
		pending_samples.push_back(s);
	endtask

	// Scan runs that settle on a target mask, with occasional contact bounce,
	// interleaved with reads and a little init and unused-operation noise.
	task automatic build_phase(input int n_items);
		int                produced;
		int                run;
		int                roll;
		int                eff;
		logic [MASK_W-1:0] target;
		logic [MASK_W-1:0] sample;
		eff = (tune_debounce == 0) ? 1 : int'(tune_debounce);
		target = MASK_W'($urandom_range(63));
		ms_now = $urandom();
		add_item(OP_INIT, target, ms_now);
		produced = 1;
		while (produced < n_items) begin
			roll = $urandom_range(99);
			if (roll < 4) begin
				target = MASK_W'($urandom_range(63));
				add_item(OP_INIT, target, $urandom());
				produced++;
			end else if (roll < 7) begin
				add_item(OP_NOP, MASK_W'($urandom_range(63)), $urandom());
				produced++;
			end else if (roll < 30) begin
				add_item(OP_READ, MASK_W'($urandom_range(63)), $urandom());
				produced++;
			end else begin
				if ($urandom_range(3) == 0)
					target = MASK_W'($urandom_range(63));
				else
					target ^= MASK_W'(1 << $urandom_range(MASK_W - 1));
				run = eff + $urandom_range(6);
				repeat (run) begin
					sample = target;
					if ($urandom_range(9) == 0)
						sample ^= MASK_W'(1 << $urandom_range(MASK_W - 1));
					// Short ticks or, most often, a chunk of the long-press time,
					// now and then a jump anywhere (wrapping the counter).
					case ($urandom_range(9))
						0: ms_now += $urandom();
						1, 2, 3, 4: ms_now += $urandom_range(20);
						default: ms_now += tune_long_ms / 3 + $urandom_range(tune_long_ms / 4);
					endcase
					add_item(OP_SCAN, sample, ms_now);
				end
				produced += run;
			end
		end
	endtask

	// Wait until every item is taken and every report has come back.
	task automatic drain();
		@(posedge clk);
		while (pending_samples.size() != 0 || in_valid || due_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] word);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= word;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_DEBOUNCE)
			tune_debounce = word[CNT_W-1:0];
		else if (idx == CFG_LONG_MS)
			tune_long_ms = word[LONG_W-1:0];
	endtask

	task automatic set_regs(input logic [CFG_DATA_W-1:0] debounce_word,
			input logic [CFG_DATA_W-1:0] long_word);
		write_reg(CFG_DEBOUNCE, debounce_word);
		write_reg(CFG_LONG_MS, long_word);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening at the reset tuning (3 samples, 1000 ms).
		add_item(OP_INIT, 6'h00, 32'h0000_0000);
		add_item(OP_READ, 6'h3F, 32'hFFFF_FFFF);
		add_item(OP_NOP, 6'h3F, 32'hFFFF_FFFF);
		// keys 0 and 4 together: the lower key wins the latch
		add_item(OP_SCAN, 6'h11, 32'h0000_0001);
		add_item(OP_SCAN, 6'h11, 32'h0000_0002);
		add_item(OP_SCAN, 6'h11, 32'h0000_0003);
		add_item(OP_READ, 6'h00, 32'h0000_0000);
		// special key press just before the tick counter wraps
		add_item(OP_SCAN, 6'h20, 32'hFFFF_FEFE);
		add_item(OP_SCAN, 6'h20, 32'hFFFF_FEFF);
		add_item(OP_SCAN, 6'h20, 32'hFFFF_FF00);
		// one tick short of the long press, then exactly on it across the wrap
		add_item(OP_SCAN, 6'h20, 32'h0000_02E7);
		add_item(OP_SCAN, 6'h20, 32'h0000_02E8);
		add_item(OP_READ, 6'h00, 32'h0000_0000);
		// release after a long press stays silent; key 4 gets the top code
		add_item(OP_SCAN, 6'h10, 32'h0000_0300);
		add_item(OP_SCAN, 6'h10, 32'h0000_0301);
		add_item(OP_SCAN, 6'h10, 32'h0000_0302);
		add_item(OP_READ, 6'h00, 32'h0000_0000);
		// short tap of the special key reports a press on release
		add_item(OP_SCAN, 6'h30, 32'h0000_0400);
		add_item(OP_SCAN, 6'h30, 32'h0000_0401);
		add_item(OP_SCAN, 6'h30, 32'h0000_0402);
		add_item(OP_SCAN, 6'h10, 32'h0000_0403);
		add_item(OP_SCAN, 6'h10, 32'h0000_0404);
		add_item(OP_SCAN, 6'h10, 32'h0000_0405);
		add_item(OP_READ, 6'h00, 32'h0000_0000);
		// special key held at init: muted until its release is accepted
		add_item(OP_INIT, 6'h3F, 32'h0000_0000);
		add_item(OP_SCAN, 6'h3F, 32'h8000_0000);
		add_item(OP_SCAN, 6'h00, 32'h8000_0001);
		add_item(OP_SCAN, 6'h00, 32'h8000_0002);
		add_item(OP_SCAN, 6'h00, 32'h8000_0003);
		add_item(OP_READ, 6'h00, 32'h0000_0000);
		build_phase(150);
		drain();

		// fastest tuning: single-sample debounce, 1 ms long press
		set_regs(16'd1, 16'd1);
		build_phase(180);
		drain();

		// slowest tuning, run back to back with no gaps on either side
		allow_gaps = 1'b0;
		set_regs(16'd15, 16'hFFFF);
		build_phase(200);
		drain();
		allow_gaps = 1'b1;

		// zero debounce acts as one; upper data bits are junk
		set_regs(16'hABC0, 16'd2);
		build_phase(180);
		drain();

		// spare indexes first, then a random tuning
		write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom()));
		write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom()));
		set_regs(CFG_DATA_W'($urandom_range(2, 14)), CFG_DATA_W'($urandom_range(1, 65535)));
		build_phase(200);
		drain();

		set_regs(16'd4, 16'd500);
		build_phase(210);
		drain();

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
